// ===== design/spsa_pkg.sv =====
// ----------------------------------------------------------------------------
// spsa_pkg
// shared types and codes of the slab pool slot allocator
// ----------------------------------------------------------------------------
package spsa_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_OPEN,
        S_A_RDCUR,
        S_A_CHK1,
        S_A_CHK2,
        S_A_USE,
        S_A_LNK,
        S_AO1,
        S_AO2,
        S_F_CHK,
        S_FM1,
        S_FM2,
        S_FM3,
        S_FM4,
        S_FM5,
        S_FM6,
        S_FIN,
        S_LK_RD,
        S_LK_WR
    } t_state;

    typedef enum logic {
        LNK_NEXT,
        LNK_PREV
    } t_lsel;

    localparam logic       OP_ALLOC    = 1'b0;
    localparam logic       OP_FREE     = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PART  = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    localparam logic       REG_SLOTS   = 1'b0;
    localparam logic       REG_CLEANUP = 1'b1;

endpackage

// ===== design/slab_pool_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// slab_pool_slot_allocator
// slot allocator over a ring of pool parts with per-part lazy free lists
// ----------------------------------------------------------------------------
// One request at a time: a beat is taken when start is high and busy is low,
// and busy stays high until the result beat, which shows on the o_ ports for
// one cycle with o_valid high and cannot be held off. The per-part counters,
// free list head and ring links sit in one part ram (the in-use flags are
// registers) and the slot links with their busy flags in one slot ram, both
// with one write and one registered read port, so every step is a read
// followed by a write. An allocate may step to the next part of the ring,
// open a part when none is current, or open a new part behind the current
// one. A free may unlink the emptied part, or move a full part behind the
// current part, which is unlinked again when it also empties. A free that
// fails the index checks is answered straight from idle without raising
// busy. The ring link updates are done one field at a time through a shared
// read-modify-write step. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module slab_pool_slot_allocator #(
    parameter int NUM_PARTS = 16,
    parameter int MAX_SLOTS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_opcode,
    input  logic [3:0] i_part_index,
    input  logic [7:0] i_slot_index,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [3:0] o_out_part,
    output logic [7:0] o_out_slot,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [8:0] i_cfg_data
);

    import spsa_pkg::*;

    // widths of part index, slot index and slot counts
    localparam int PW = $clog2(NUM_PARTS);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    // part entry: {used, ever, head, next, prev}
    localparam int EW = 3 * CW + 2 * PW;
    localparam int SLOT_DEPTH = 1 << (PW + SW);

    t_state          r_state, n_state;
    logic [8:0]      r_spp;
    logic            r_cleanup;
    logic [NUM_PARTS-1:0] r_inuse, n_inuse;
    logic [PW-1:0]   r_cur, n_cur;
    logic            r_have, n_have;
    logic [PW-1:0]   r_pi, n_pi;
    logic [SW-1:0]   r_si, n_si;
    logic [EW-1:0]   r_ent, n_ent;
    logic [PW-1:0]   r_p, n_p;
    logic [PW-1:0]   r_a, n_a;
    logic [PW-1:0]   r_b, n_b;
    logic [PW-1:0]   r_n, n_n;
    logic            r_move, n_move;
    logic            r_empty, n_empty;
    logic [PW-1:0]   r_la, n_la;
    t_lsel           r_lsel, n_lsel;
    logic [PW-1:0]   r_lv, n_lv;
    logic            r_lcap, n_lcap;
    t_state          r_lret, n_lret;
    logic            r_valid, n_valid;
    logic [1:0]      r_status, n_status;
    logic [PW-1:0]   r_opart, n_opart;
    logic [SW-1:0]   r_oslot, n_oslot;

    // ram ports
    logic               part_we;
    logic [PW-1:0]      part_waddr, part_raddr;
    logic [EW-1:0]      part_wdata, part_q;
    logic               slot_we;
    logic [PW+SW-1:0]   slot_waddr, slot_raddr;
    logic [CW:0]        slot_wdata, slot_q;

    spsa_ram #(.WIDTH(EW), .DEPTH(NUM_PARTS)) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (part_we),
        .i_waddr (part_waddr),
        .i_wdata (part_wdata),
        .i_raddr (part_raddr),
        .o_rdata (part_q)
    );

    spsa_ram #(.WIDTH(CW + 1), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_q)
    );

    // fields of the part entry just read
    logic [CW-1:0] q_used, q_ever, q_head;
    logic [PW-1:0] q_nxt, q_prv;
    assign q_used = part_q[EW-1 -: CW];
    assign q_ever = part_q[EW-1-CW -: CW];
    assign q_head = part_q[2*PW+CW-1 -: CW];
    assign q_nxt  = part_q[2*PW-1 -: PW];
    assign q_prv  = part_q[PW-1:0];

    // fields of the held entry of the part being allocated from
    logic [CW-1:0] e_used, e_ever, e_head;
    logic [PW-1:0] e_nxt, e_prv;
    logic [SW-1:0] e_s;
    assign e_used = r_ent[EW-1 -: CW];
    assign e_ever = r_ent[EW-1-CW -: CW];
    assign e_head = r_ent[2*PW+CW-1 -: CW];
    assign e_nxt  = r_ent[2*PW-1 -: PW];
    assign e_prv  = r_ent[PW-1:0];
    // free list head taken modulo the slot count
    assign e_s    = (e_head == CW'(MAX_SLOTS)) ? '0 : e_head[SW-1:0];

    // effective capacity, clamped to 1..MAX_SLOTS
    logic [CW-1:0] cap;
    always_comb begin
        if (r_spp == 9'd0) begin
            cap = CW'(1);
        end else if (int'(r_spp) > MAX_SLOTS) begin
            cap = CW'(MAX_SLOTS);
        end else begin
            cap = CW'(r_spp);
        end
    end

    // lowest unused part
    logic          free_ok;
    logic [PW-1:0] free_p;
    always_comb begin
        free_ok = 1'b0;
        free_p  = '0;
        for (int i = NUM_PARTS - 1; i >= 0; i--) begin
            if (!r_inuse[i]) begin
                free_ok = 1'b1;
                free_p  = PW'(i);
            end
        end
    end

    // decode of the incoming request and of the read data
    logic          acc;
    logic          in_bad;
    logic          q_full;
    logic          f_bad;
    logic [CW-1:0] f_used;
    logic          f_move;
    logic          f_empty;
    logic          f_single;
    assign acc    = start && !busy;
    assign in_bad = (int'(i_part_index) >= NUM_PARTS) || (int'(i_slot_index) >= MAX_SLOTS)
                    || !r_inuse[PW'(i_part_index)];
    assign q_full = (q_used >= cap);
    assign f_bad  = (CW'(r_si) >= q_ever) || !slot_q[CW];
    assign f_used = (q_used != '0) ? (q_used - CW'(1)) : '0;
    assign f_move = q_full && (q_nxt != r_pi) && (r_cur != r_pi);
    assign f_empty = (f_used == '0);
    assign f_single = (q_nxt == r_pi);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_opcode == OP_ALLOC) begin
                        n_state = r_have ? S_A_CHK1 : S_A_OPEN;
                    end else if (!in_bad) begin
                        n_state = S_F_CHK;
                    end
                end
            end
            S_A_OPEN:  n_state = free_ok ? S_A_RDCUR : S_IDLE;
            S_A_RDCUR: n_state = S_A_CHK1;
            S_A_CHK1:  n_state = q_full ? S_A_CHK2 : S_A_USE;
            S_A_CHK2: begin
                if (!q_full) begin
                    n_state = S_A_USE;
                end else begin
                    n_state = free_ok ? S_AO1 : S_IDLE;
                end
            end
            S_A_USE:   n_state = (e_used == e_ever) ? S_IDLE : S_A_LNK;
            S_A_LNK:   n_state = S_IDLE;
            S_F_CHK: begin
                if (f_bad) begin
                    n_state = S_IDLE;
                end else if (f_move) begin
                    n_state = S_FM1;
                end else if (f_empty && !f_single) begin
                    n_state = S_FM1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_AO1, S_AO2, S_FM1, S_FM2, S_FM3, S_FM4, S_FM5, S_FM6: begin
                n_state = S_LK_RD;
            end
            S_FIN:     n_state = S_IDLE;
            S_LK_RD:   n_state = S_LK_WR;
            S_LK_WR:   n_state = r_lret;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and ram controls
    always_comb begin
        n_inuse  = r_inuse;
        n_cur    = r_cur;
        n_have   = r_have;
        n_pi     = r_pi;
        n_si     = r_si;
        n_ent    = r_ent;
        n_p      = r_p;
        n_a      = r_a;
        n_b      = r_b;
        n_n      = r_n;
        n_move   = r_move;
        n_empty  = r_empty;
        n_la     = r_la;
        n_lsel   = r_lsel;
        n_lv     = r_lv;
        n_lcap   = r_lcap;
        n_lret   = r_lret;
        n_valid  = 1'b0;
        n_status = r_status;
        n_opart  = r_opart;
        n_oslot  = r_oslot;
        part_we    = 1'b0;
        part_waddr = r_cur;
        part_wdata = part_q;
        part_raddr = r_cur;
        slot_we    = 1'b0;
        slot_waddr = {r_pi, r_si};
        slot_wdata = slot_q;
        slot_raddr = {r_pi, r_si};
        case (r_state)
            S_IDLE: begin
                part_raddr = PW'(i_part_index);
                slot_raddr = {PW'(i_part_index), SW'(i_slot_index)};
                if (acc) begin
                    n_pi = PW'(i_part_index);
                    n_si = SW'(i_slot_index);
                    if (i_opcode == OP_ALLOC) begin
                        part_raddr = r_cur;
                    end else if (in_bad) begin
                        n_valid  = 1'b1;
                        n_status = ST_BAD_FREE;
                        n_opart  = '0;
                        n_oslot  = '0;
                    end
                end
            end
            S_A_OPEN: begin
                if (!free_ok) begin
                    n_valid  = 1'b1;
                    n_status = ST_NO_PART;
                    n_opart  = '0;
                    n_oslot  = '0;
                end else begin
                    // fresh part, linked to itself
                    part_we    = 1'b1;
                    part_waddr = free_p;
                    part_wdata = {{(3*CW){1'b0}}, free_p, free_p};
                    n_inuse[free_p] = 1'b1;
                    n_cur  = free_p;
                    n_have = 1'b1;
                end
            end
            S_A_RDCUR: begin
                part_raddr = r_cur;
            end
            S_A_CHK1: begin
                n_ent = part_q;
                if (q_full) begin
                    // step to the next part of the ring
                    n_cur      = q_nxt;
                    part_raddr = q_nxt;
                end
            end
            S_A_CHK2: begin
                n_ent = part_q;
                if (q_full) begin
                    if (!free_ok) begin
                        n_valid  = 1'b1;
                        n_status = ST_NO_PART;
                        n_opart  = '0;
                        n_oslot  = '0;
                    end else begin
                        // new part right after the current one
                        part_we    = 1'b1;
                        part_waddr = free_p;
                        part_wdata = {{(3*CW){1'b0}}, q_nxt, r_cur};
                        n_inuse[free_p] = 1'b1;
                        n_p = free_p;
                        n_b = q_nxt;
                    end
                end
            end
            S_A_USE: begin
                slot_raddr = {r_cur, e_s};
                if (e_used == e_ever) begin
                    // fresh slot from the never-used tail
                    part_we    = 1'b1;
                    part_waddr = r_cur;
                    part_wdata = {e_used + CW'(1), e_ever + CW'(1), CW'(e_s) + CW'(1),
                                  e_nxt, e_prv};
                    slot_we    = 1'b1;
                    slot_waddr = {r_cur, e_s};
                    slot_wdata = {1'b1, {CW{1'b0}}};
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_opart  = r_cur;
                    n_oslot  = e_s;
                end
            end
            S_A_LNK: begin
                // pop the free list
                part_we    = 1'b1;
                part_waddr = r_cur;
                part_wdata = {e_used + CW'(1), e_ever, slot_q[CW-1:0], e_nxt, e_prv};
                slot_we    = 1'b1;
                slot_waddr = {r_cur, e_s};
                slot_wdata = {1'b1, slot_q[CW-1:0]};
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_opart  = r_cur;
                n_oslot  = e_s;
            end
            S_AO1: begin
                n_la   = r_cur;
                n_lsel = LNK_NEXT;
                n_lv   = r_p;
                n_lcap = 1'b0;
                n_lret = S_AO2;
            end
            S_AO2: begin
                n_la   = r_b;
                n_lsel = LNK_PREV;
                n_lv   = r_p;
                n_lcap = 1'b0;
                n_lret = S_A_RDCUR;
                n_cur  = r_p;
            end
            S_F_CHK: begin
                if (f_bad) begin
                    n_valid  = 1'b1;
                    n_status = ST_BAD_FREE;
                    n_opart  = '0;
                    n_oslot  = '0;
                end else begin
                    // push the slot and update the counters
                    slot_we    = 1'b1;
                    slot_waddr = {r_pi, r_si};
                    slot_wdata = {1'b0, q_head};
                    part_we    = 1'b1;
                    part_waddr = r_pi;
                    part_wdata = {f_used, q_ever, CW'(r_si), q_nxt, q_prv};
                    n_a     = q_prv;
                    n_b     = q_nxt;
                    n_move  = f_move;
                    n_empty = f_empty;
                    if (f_empty && (f_move || !f_single || (r_cleanup != 1'b0))) begin
                        n_inuse[r_pi] = 1'b0;
                    end
                    if (!f_move && f_empty) begin
                        if (f_single) begin
                            if (r_cleanup) begin
                                n_have = 1'b0;
                                n_cur  = '0;
                            end
                        end else if (r_cur == r_pi) begin
                            n_cur = q_nxt;
                        end
                    end
                    if (!f_move && !(f_empty && !f_single)) begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_opart  = '0;
                        n_oslot  = '0;
                    end
                end
            end
            S_FM1: begin
                // unlink: next of prev
                n_la   = r_a;
                n_lsel = LNK_NEXT;
                n_lv   = r_b;
                n_lcap = 1'b0;
                n_lret = S_FM2;
            end
            S_FM2: begin
                // unlink: prev of next
                n_la   = r_b;
                n_lsel = LNK_PREV;
                n_lv   = r_a;
                n_lcap = 1'b0;
                n_lret = r_move ? S_FM3 : S_FIN;
            end
            S_FM3: begin
                n_la   = r_cur;
                n_lsel = LNK_NEXT;
                n_lv   = r_pi;
                n_lcap = 1'b1;
                n_lret = S_FM4;
            end
            S_FM4: begin
                n_la   = r_n;
                n_lsel = LNK_PREV;
                n_lv   = r_pi;
                n_lcap = 1'b0;
                n_lret = S_FM5;
            end
            S_FM5: begin
                n_la   = r_pi;
                n_lsel = LNK_NEXT;
                n_lv   = r_n;
                n_lcap = 1'b0;
                n_lret = S_FM6;
            end
            S_FM6: begin
                n_la   = r_pi;
                n_lsel = LNK_PREV;
                n_lv   = r_cur;
                n_lcap = 1'b0;
                if (r_empty) begin
                    // moved part empties too: unlink it again
                    n_a    = r_cur;
                    n_b    = r_n;
                    n_move = 1'b0;
                    n_lret = S_FM1;
                end else begin
                    n_lret = S_FIN;
                end
            end
            S_FIN: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_opart  = '0;
                n_oslot  = '0;
            end
            S_LK_RD: begin
                part_raddr = r_la;
            end
            S_LK_WR: begin
                part_we    = 1'b1;
                part_waddr = r_la;
                if (r_lsel == LNK_NEXT) begin
                    part_wdata = {part_q[EW-1:2*PW], r_lv, q_prv};
                end else begin
                    part_wdata = {part_q[EW-1:PW], r_lv};
                end
                if (r_lcap) begin
                    n_n = q_nxt;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_spp     <= 9'd256;
            r_cleanup <= 1'b0;
            r_inuse   <= '0;
            r_cur     <= '0;
            r_have    <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inuse <= n_inuse;
            r_cur   <= n_cur;
            r_have  <= n_have;
            r_valid <= n_valid;
            if (i_cfg_we && (i_cfg_idx == REG_SLOTS)) begin
                r_spp <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == REG_CLEANUP)) begin
                r_cleanup <= i_cfg_data[0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pi     <= n_pi;
        r_si     <= n_si;
        r_ent    <= n_ent;
        r_p      <= n_p;
        r_a      <= n_a;
        r_b      <= n_b;
        r_n      <= n_n;
        r_move   <= n_move;
        r_empty  <= n_empty;
        r_la     <= n_la;
        r_lsel   <= n_lsel;
        r_lv     <= n_lv;
        r_lcap   <= n_lcap;
        r_lret   <= n_lret;
        r_status <= n_status;
        r_opart  <= n_opart;
        r_oslot  <= n_oslot;
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_out_part = 4'(r_opart);
    assign o_out_slot = 8'(r_oslot);

    // a result beat only shows once the request is finished
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // an accepted allocate always goes to work
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_ALLOC)) |=> busy)
        else $error("allocate not started");

    // the current part is always in use while there is one
    a_cur_inuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> r_inuse[r_cur])
        else $error("current part not in use");

    // without a current part the pointer sits at zero
    a_cur_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_cur == '0))
        else $error("stale current part");

endmodule

// ===== design/spsa_ram.sv =====
// ----------------------------------------------------------------------------
// spsa_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module spsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
